[rtl/sdpc_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// sdpc_pkg
// Shared types and constants of the straight drive proportional controller.
// ---------------------------------------------------------------------------
package sdpc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_POWER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_PCT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DEG  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_START  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_END    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_FACTOR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH      = 3'd7;

    // field widths
    localparam int DIST_W = 20;
    localparam int PWR_W  = 20;
    localparam int MV_W   = 15;

    // power arithmetic
    localparam int EMAG_W = 30;              // |error| in percent * 400
    localparam int DV_W   = 29;              // 400 * target
    localparam int NUM_W  = 45;              // |error| * speed * 256
    localparam int Q_W    = 19;              // quotient bits below saturation
    localparam int DIV_STEPS = Q_W;
    localparam int DIV_CNT_W = 5;

    localparam logic signed [PWR_W-1:0] PWR_MAX = 20'sh7FFFF;
    localparam logic signed [PWR_W-1:0] PWR_MIN = 20'sh80000;

    // millivolt scaling: trunc(|x| * 120 / 25600), saturating at 12000
    localparam logic [21:0]     X_SAT    = 22'd2560214;
    localparam logic [19:0]     RECIP_25 = 20'd671089;   // ceil(2^24 / 25)
    localparam int              V_W      = 19;
    localparam logic [MV_W-1:0] MV_LIMIT = 15'd12000;

    typedef struct packed {
        logic signed [1:0]        direction;
        logic signed [15:0]       init_power;
        logic [6:0]               speed_pct;
        logic [DIST_W-1:0]        target_deg;
        logic [DIST_W-1:0]        ramp_start_deg;
        logic [DIST_W-1:0]        ramp_end_deg;
        logic [7:0]               slow_factor_pct;
        logic                     smooth;
    } t_cfg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture input item
        logic mag;      // sums, magnitude, restart
        logic test;     // distance tests, error terms, done result
        logic pmul;     // error times speed
        logic dchk;     // overflow check, divider init
        logic dstep;    // one divider step
        logic dlast;    // last divider step, write power
        logic dmul;     // drift product
        logic scale;    // side sums, millivolt scaling
        logic recip;    // divide by 25, saturate, sign
        logic oload;    // move result to output register
    } t_cmd;

    // status from the datapath
    typedef struct packed {
        logic hit;      // target reached
        logic in_win;   // inside ramp window
        logic ovf;      // power quotient saturates
    } t_sts;

endpackage
`default_nettype wire

[rtl/sdpc_cfg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// sdpc_cfg
// Configuration register file, written one register per write.
// ---------------------------------------------------------------------------
module sdpc_cfg import sdpc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_we,
    input  wire logic [CFG_IDX_W-1:0]  i_index,
    input  wire logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_index)
                CFG_DIRECTION:   n_cfg.direction       = i_data[1:0];
                CFG_INIT_POWER:  n_cfg.init_power      = i_data[15:0];
                CFG_SPEED_PCT:   n_cfg.speed_pct       = i_data[6:0];
                CFG_TARGET_DEG:  n_cfg.target_deg      = i_data[DIST_W-1:0];
                CFG_RAMP_START:  n_cfg.ramp_start_deg  = i_data[DIST_W-1:0];
                CFG_RAMP_END:    n_cfg.ramp_end_deg    = i_data[DIST_W-1:0];
                CFG_SLOW_FACTOR: n_cfg.slow_factor_pct = i_data[7:0];
                CFG_SMOOTH:      n_cfg.smooth          = i_data[0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction       <= 2'sd1;
            r_cfg.init_power      <= '0;
            r_cfg.speed_pct       <= 7'd50;
            r_cfg.target_deg      <= 20'd1000;
            r_cfg.ramp_start_deg  <= '0;
            r_cfg.ramp_end_deg    <= 20'd1000;
            r_cfg.slow_factor_pct <= 8'd100;
            r_cfg.smooth          <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[rtl/sdpc_ctrl.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// sdpc_ctrl
// Sequencer: steps one item through the datapath, owns the handshakes.
// ---------------------------------------------------------------------------
module sdpc_ctrl import sdpc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MAG   = 4'd1;
    localparam logic [3:0] ST_TEST  = 4'd2;
    localparam logic [3:0] ST_PMUL  = 4'd3;
    localparam logic [3:0] ST_DCHK  = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_DMUL  = 4'd6;
    localparam logic [3:0] ST_SCALE = 4'd7;
    localparam logic [3:0] ST_RECIP = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    logic [3:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_oval, n_oval;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MAG;
                end
            end
            ST_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = ST_TEST;
            end
            ST_TEST: begin
                o_cmd.test = 1'b1;
                priority if (i_sts.hit) begin
                    n_state = ST_FIN;
                end else if (i_sts.in_win) begin
                    n_state = ST_PMUL;
                end else begin
                    n_state = ST_DMUL;
                end
            end
            ST_PMUL: begin
                o_cmd.pmul = 1'b1;
                n_state    = ST_DCHK;
            end
            ST_DCHK: begin
                o_cmd.dchk = 1'b1;
                n_cnt      = '0;
                n_state    = i_sts.ovf ? ST_DMUL : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.dstep = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    o_cmd.dlast = 1'b1;
                    n_state     = ST_DMUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DMUL: begin
                o_cmd.dmul = 1'b1;
                n_state    = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_RECIP;
            end
            ST_RECIP: begin
                o_cmd.recip = 1'b1;
                n_state     = ST_FIN;
            end
            ST_FIN: begin
                if (!r_oval || !i_stall) begin
                    o_cmd.oload = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output item valid
    always_comb begin
        n_oval = r_oval;
        priority if (o_cmd.oload) begin
            n_oval = 1'b1;
        end else if (!i_stall) begin
            n_oval = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_oval  <= n_oval;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_oval;

endmodule
`default_nettype wire

[rtl/sdpc_dp.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// sdpc_dp
// Datapath: encoder sums, power update through a restoring divider,
// drift product and millivolt scaling with saturation.
// ---------------------------------------------------------------------------
module sdpc_dp import sdpc_pkg::*; #(
    parameter int ENC_BITS = 24
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cfg                       i_cfg,
    input  wire t_cmd                       i_cmd,
    output t_sts                            o_sts,
    input  wire logic signed [ENC_BITS-1:0] i_front_left,
    input  wire logic signed [ENC_BITS-1:0] i_front_right,
    input  wire logic signed [ENC_BITS-1:0] i_back_left,
    input  wire logic signed [ENC_BITS-1:0] i_back_right,
    input  wire logic                       i_restart,
    output logic signed [MV_W-1:0]          o_left_mv,
    output logic signed [MV_W-1:0]          o_right_mv,
    output logic                            o_done_res
);

    localparam int S_W  = ENC_BITS + 2;          // sum of four encoders
    localparam int CW   = (S_W > 22) ? S_W : 22; // distance compare width
    localparam int M_W  = S_W + PWR_W;           // side difference * power
    localparam int X_W  = M_W + 3;               // 100 * power +- 4 * drift

    // captured input item
    logic signed [ENC_BITS-1:0] r_fl, r_fr, r_bl, r_br;
    logic                       r_restart;

    // distances
    logic [S_W-1:0]        r_a;
    logic signed [S_W-1:0] r_dd;
    logic signed [S_W-1:0] sum_all, sum_dd;

    // power update
    logic signed [PWR_W-1:0] r_held;
    logic [EMAG_W-1:0]       r_emag;
    logic                    r_eneg;
    logic [DV_W-1:0]         r_dv;
    logic [NUM_W-Q_W-1:0]    r_nhi;
    logic [Q_W-1:0]          r_nlo;
    logic [DV_W:0]           r_rem;
    logic [Q_W-1:0]          r_q;

    // drive
    logic signed [M_W-1:0] r_m;
    logic [V_W-1:0]        r_v_l, r_v_r;
    logic                  r_sat_l, r_sat_r, r_neg_l, r_neg_r;
    logic signed [MV_W-1:0] r_res_l, r_res_r;
    logic                   r_res_done;
    logic signed [MV_W-1:0] r_out_l, r_out_r;
    logic                   r_out_done;

    // direction decode: pattern -2 acts as -1
    logic d_zero, d_neg;
    assign d_zero = (i_cfg.direction == 2'sd0);
    assign d_neg  = i_cfg.direction[1];

    // encoder sums
    always_comb begin
        sum_all = S_W'(r_fl) + S_W'(r_fr) + S_W'(r_bl) + S_W'(r_br);
        sum_dd  = S_W'(r_fr) + S_W'(r_br) - S_W'(r_fl) - S_W'(r_bl);
    end

    // distance tests against four times the register
    logic [21:0] tgt4, start4, end4;
    assign tgt4   = {i_cfg.target_deg, 2'b00};
    assign start4 = {i_cfg.ramp_start_deg, 2'b00};
    assign end4   = {i_cfg.ramp_end_deg, 2'b00};

    always_comb begin
        o_sts.hit    = (CW'(r_a) >= CW'(tgt4));
        o_sts.in_win = (CW'(r_a) <= CW'(end4)) && (CW'(r_a) > CW'(start4));
        o_sts.ovf    = ({{(DV_W-(NUM_W-Q_W)){1'b0}}, r_nhi} >= r_dv);
    end

    // error terms; inside the window the distance fits 22 bits
    logic [DIST_W:0]   tgt_off;
    logic [EMAG_W-1:0] pos_term, neg_term;
    logic [21:0]       a_lo;
    logic [DV_W-1:0]   dv;
    always_comb begin
        a_lo     = 22'(r_a);
        tgt_off  = {1'b0, i_cfg.target_deg}
                 + (i_cfg.smooth ? {1'b0, i_cfg.ramp_start_deg} : '0);
        pos_term = EMAG_W'(tgt_off) * EMAG_W'(400);
        neg_term = EMAG_W'(a_lo) * EMAG_W'(i_cfg.slow_factor_pct);
        dv       = DV_W'(i_cfg.target_deg) * DV_W'(400);
    end

    // numerator magnitude
    logic [NUM_W-9:0] prod;
    assign prod = (NUM_W-8)'(r_emag) * (NUM_W-8)'(i_cfg.speed_pct);

    // divider step
    logic [DV_W:0]  rem_sh;
    logic           q_bit;
    logic [Q_W-1:0] q_next;
    always_comb begin
        rem_sh = {r_rem[DV_W-1:0], r_nlo[Q_W-1]};
        q_bit  = (rem_sh >= {1'b0, r_dv});
        q_next = {r_q[Q_W-2:0], q_bit};
    end

    // side sums: 100 * p +- 4 * drift * d
    logic signed [X_W-1:0] p_ext, p100, m4, drift, x_l, x_r;
    logic [X_W-1:0]        ax_l, ax_r;
    logic [28:0]           sc_l, sc_r;
    always_comb begin
        p_ext = X_W'(r_held);
        p100  = (p_ext <<< 6) + (p_ext <<< 5) + (p_ext <<< 2);
        m4    = X_W'(r_m) <<< 2;
        drift = d_zero ? '0 : (d_neg ? -m4 : m4);
        x_l   = p100 + drift;
        x_r   = p100 - drift;
        ax_l  = x_l[X_W-1] ? X_W'(-x_l) : X_W'(x_l);
        ax_r  = x_r[X_W-1] ? X_W'(-x_r) : X_W'(x_r);
        sc_l  = 29'(ax_l[21:0]) * 29'(120);
        sc_r  = 29'(ax_r[21:0]) * 29'(120);
    end

    // divide by 25 through a reciprocal, saturate, apply sign
    logic [38:0]            rc_l, rc_r;
    logic [MV_W-1:0]        mag_l, mag_r;
    logic signed [MV_W-1:0] res_l, res_r;
    always_comb begin
        rc_l  = 39'(r_v_l) * 39'(RECIP_25);
        rc_r  = 39'(r_v_r) * 39'(RECIP_25);
        mag_l = r_sat_l ? MV_LIMIT : rc_l[38:24];
        mag_r = r_sat_r ? MV_LIMIT : rc_r[38:24];
        res_l = d_zero ? '0 : (r_neg_l ? -mag_l : mag_l);
        res_r = d_zero ? '0 : (r_neg_r ? -mag_r : mag_r);
    end

    // held power
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            if (i_cmd.mag && r_restart) begin
                r_held <= PWR_W'(i_cfg.init_power);
            end
            if (i_cmd.dchk && o_sts.ovf) begin
                r_held <= r_eneg ? PWR_MIN : PWR_MAX;
            end
            if (i_cmd.dlast) begin
                r_held <= r_eneg ? -PWR_W'({1'b0, q_next}) : PWR_W'({1'b0, q_next});
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fl      <= i_front_left;
            r_fr      <= i_front_right;
            r_bl      <= i_back_left;
            r_br      <= i_back_right;
            r_restart <= i_restart;
        end
        if (i_cmd.mag) begin
            r_a  <= sum_all[S_W-1] ? S_W'(-sum_all) : S_W'(sum_all);
            r_dd <= sum_dd;
        end
        if (i_cmd.test) begin
            r_eneg <= (neg_term > pos_term);
            r_emag <= (neg_term > pos_term) ? neg_term - pos_term : pos_term - neg_term;
            r_dv   <= dv;
            if (o_sts.hit) begin
                r_res_l    <= '0;
                r_res_r    <= '0;
                r_res_done <= 1'b1;
            end
        end
        if (i_cmd.pmul) begin
            {r_nhi, r_nlo} <= {prod, 8'b0};
        end
        if (i_cmd.dchk) begin
            r_rem <= (DV_W+1)'(r_nhi);
            r_q   <= '0;
        end
        if (i_cmd.dstep) begin
            r_rem <= q_bit ? rem_sh - {1'b0, r_dv} : rem_sh;
            r_nlo <= {r_nlo[Q_W-2:0], 1'b0};
            r_q   <= q_next;
        end
        if (i_cmd.dmul) begin
            r_m <= M_W'(r_dd) * M_W'(r_held);
        end
        if (i_cmd.scale) begin
            r_sat_l <= (ax_l >= X_W'(X_SAT));
            r_sat_r <= (ax_r >= X_W'(X_SAT));
            r_neg_l <= x_l[X_W-1] ^ d_neg;
            r_neg_r <= x_r[X_W-1] ^ d_neg;
            r_v_l   <= sc_l[28:10];
            r_v_r   <= sc_r[28:10];
        end
        if (i_cmd.recip) begin
            r_res_l    <= res_l;
            r_res_r    <= res_r;
            r_res_done <= 1'b0;
        end
        if (i_cmd.oload) begin
            r_out_l    <= r_res_l;
            r_out_r    <= r_res_r;
            r_out_done <= r_res_done;
        end
    end

    assign o_left_mv  = r_out_l;
    assign o_right_mv = r_out_r;
    assign o_done_res = r_out_done;

endmodule
`default_nettype wire

[rtl/straight_drive_p_control_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// straight_drive_p_control_unit
// Straight drive proportional controller with left/right drift correction.
// ---------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ---------------------------------------
//  input     i_valid / o_stall       i_front_left, i_front_right,
//                                    i_back_left, i_back_right, i_restart
//  output    o_valid / i_stall       o_left_mv, o_right_mv, o_done_res
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  one item at a time: the sequence ends after the tests when the target is
//  reached, skips the divider outside the ramp window or when the power
//  saturates, and runs the 19 step restoring divider when it is recomputed.
//  reset restores register defaults and zero held power; no clearing pass.
//  the result sits in an output register, so a stalled output blocks a new
//  item only once the next result is ready.
//
module straight_drive_p_control_unit import sdpc_pkg::*; #(
    parameter int ENC_BITS = 24
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input item
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic signed [ENC_BITS-1:0] i_front_left,
    input  wire logic signed [ENC_BITS-1:0] i_front_right,
    input  wire logic signed [ENC_BITS-1:0] i_back_left,
    input  wire logic signed [ENC_BITS-1:0] i_back_right,
    input  wire logic                       i_restart,
    // output item
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [MV_W-1:0]          o_left_mv,
    output logic signed [MV_W-1:0]          o_right_mv,
    output logic                            o_done_res,
    // configuration writes
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    sdpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    sdpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sdpc_dp #(
        .ENC_BITS (ENC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_front_left  (i_front_left),
        .i_front_right (i_front_right),
        .i_back_left   (i_back_left),
        .i_back_right  (i_back_right),
        .i_restart     (i_restart),
        .o_left_mv     (o_left_mv),
        .o_right_mv    (o_right_mv),
        .o_done_res    (o_done_res)
    );

endmodule
`default_nettype wire
